/* hdl/undirected_tree_check_defines.svh */
// -----------------------------------------------------------------------------
// Undirected tree check assertion macros
// Shared property shapes for the block's concurrent assertions.
// -----------------------------------------------------------------------------
`ifndef UNDIRECTED_TREE_CHECK_DEFINES_SVH
`define UNDIRECTED_TREE_CHECK_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UTC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define UTC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/utc_pkg.sv */
// -----------------------------------------------------------------------------
// Undirected tree check package
// Types, constants and helper functions shared by the controller and datapath.
// -----------------------------------------------------------------------------
package utc_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int VTX_W        = $clog2(MAX_VERTICES);
  localparam int CNT_W        = 7;

  localparam logic MODE_ADD  = 1'b0;
  localparam logic MODE_EVAL = 1'b1;

  typedef logic [MAX_VERTICES-1:0] vset_t;

  typedef struct packed {
    logic             mode;
    logic [VTX_W-1:0] end_a;
    logic [VTX_W-1:0] end_b;
  } utc_in_t;

  typedef struct packed {
    logic is_tree;
    logic has_cycle;
    logic all_reached;
    logic range_error;
  } utc_out_t;

  typedef struct packed {
    logic [VTX_W-1:0] vtx;
    logic [VTX_W-1:0] par;
  } utc_frame_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EDGE,
    S_POP,
    S_FETCH,
    S_SCAN,
    S_PUSH,
    S_FINISH
  } utc_state_t;

  typedef struct packed {
    logic load_edge;
    logic edge_second;
    logic start_walk;
    logic pop;
    logic fetch;
    logic scan;
    logic push;
    logic finish;
    logic clear;
  } utc_cmd_t;

  typedef struct packed {
    logic edge_ok;
    logic n_zero;
    logic pending_any;
    logic stack_empty;
    logic clear_last;
    logic out_free;
  } utc_status_t;

  function automatic vset_t mask_below(logic [CNT_W-1:0] n);
    vset_t m;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      m[i] = (CNT_W'(i) < n);
    end
    return m;
  endfunction

  function automatic logic [VTX_W-1:0] low_index(vset_t v);
    vset_t            onehot;
    logic [VTX_W-1:0] idx;
    onehot = v & (~v + vset_t'(1));
    idx    = '0;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      if (onehot[i]) begin
        idx = idx | VTX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

/* hdl/utc_ctrl.sv */
// -----------------------------------------------------------------------------
// Undirected tree check controller
// Sequences edge loads, the depth-first walk, result hand-off and clearing.
// -----------------------------------------------------------------------------
module utc_ctrl
  import utc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_mode,
  output logic        in_ready,
  input  utc_status_t status,
  output utc_cmd_t    cmd
);

  utc_state_t state;
  utc_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_mode == MODE_EVAL) begin
            cmd.start_walk = 1'b1;
            state_next     = status.n_zero ? S_FINISH : S_POP;
          end else begin
            cmd.load_edge = 1'b1;
            if (status.edge_ok) begin
              state_next = S_EDGE;
            end
          end
        end
      end
      S_EDGE: begin
        cmd.edge_second = 1'b1;
        state_next      = S_IDLE;
      end
      S_POP: begin
        cmd.pop    = 1'b1;
        state_next = S_FETCH;
      end
      S_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan   = 1'b1;
        state_next = S_PUSH;
      end
      S_PUSH: begin
        if (status.pending_any) begin
          cmd.push = 1'b1;
        end else if (status.stack_empty) begin
          state_next = S_FINISH;
        end else begin
          state_next = S_POP;
        end
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_CLEAR;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

/* hdl/utc_dpath.sv */
// -----------------------------------------------------------------------------
// Undirected tree check datapath
// Adjacency store, walk stack, visited marks, flags and the result register.
// -----------------------------------------------------------------------------
`include "undirected_tree_check_defines.svh"

module utc_dpath
  import utc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  utc_in_t          in_data,
  input  logic             cfg_write,
  input  logic [CNT_W-1:0] cfg_data,
  input  utc_cmd_t         cmd,
  output utc_status_t      status,
  output logic             out_valid,
  input  logic             out_ready,
  output utc_out_t         out_data
);

  vset_t            adj [MAX_VERTICES];
  utc_frame_t       stack [MAX_VERTICES];

  logic [CNT_W-1:0] vertex_count;
  logic [CNT_W-1:0] sp;
  logic [VTX_W-1:0] clr;
  vset_t            visited;
  logic             cyc;
  logic             bad;

  vset_t            adj_q;
  utc_frame_t       stack_q;
  logic [VTX_W-1:0] cur_vtx;
  logic [VTX_W-1:0] cur_par;
  logic [VTX_W-1:0] edge_a;
  logic [VTX_W-1:0] edge_b;
  vset_t            pending;

  logic [CNT_W-1:0] n_act;
  vset_t            mask;
  logic             edge_ok;
  logic [CNT_W-1:0] sp_dec;
  vset_t            row_m;
  vset_t            fresh;
  vset_t            par_bit;
  logic             bit_we;
  logic [VTX_W-1:0] bit_row;
  logic [VTX_W-1:0] bit_col;
  logic             stk_we;
  logic [VTX_W-1:0] stk_addr;
  utc_frame_t       stk_wdata;
  logic             reached;

  assign n_act   = (vertex_count > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : vertex_count;
  assign mask    = mask_below(n_act);
  assign edge_ok = ({1'b0, in_data.end_a} < n_act) && ({1'b0, in_data.end_b} < n_act);
  assign sp_dec  = sp - CNT_W'(1);
  assign row_m   = adj_q & mask;
  assign fresh   = row_m & ~visited;
  assign par_bit = vset_t'(1) << cur_par;
  assign reached = ((visited & mask) == mask);

  assign bit_we  = (cmd.load_edge && edge_ok) || cmd.edge_second;
  assign bit_row = cmd.edge_second ? edge_b : in_data.end_a;
  assign bit_col = cmd.edge_second ? edge_a : in_data.end_b;

  assign stk_we    = (cmd.start_walk && (n_act != '0)) || cmd.push;
  assign stk_addr  = cmd.push ? sp[VTX_W-1:0] : '0;
  assign stk_wdata = cmd.push ? utc_frame_t'{vtx: low_index(pending), par: cur_vtx} : '0;

  assign status.edge_ok     = edge_ok;
  assign status.n_zero      = (n_act == '0);
  assign status.pending_any = (pending != '0);
  assign status.stack_empty = (sp == '0);
  assign status.clear_last  = (clr == VTX_W'(MAX_VERTICES - 1));
  assign status.out_free    = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (bit_we) begin
      adj[bit_row][bit_col] <= 1'b1;
    end else if (cmd.clear) begin
      adj[clr] <= '0;
    end
    if (cmd.fetch) begin
      adj_q <= adj[stack_q.vtx];
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stack[stk_addr] <= stk_wdata;
    end
    if (cmd.pop) begin
      stack_q <= stack[sp_dec[VTX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_edge) begin
      edge_a <= in_data.end_a;
      edge_b <= in_data.end_b;
    end
    if (cmd.fetch) begin
      cur_vtx <= stack_q.vtx;
      cur_par <= stack_q.par;
    end
    if (cmd.scan) begin
      pending <= fresh;
    end else if (cmd.push) begin
      pending <= pending & (pending - vset_t'(1));
    end
    if (cmd.finish) begin
      out_data.has_cycle   <= cyc;
      out_data.all_reached <= reached;
      out_data.is_tree     <= !cyc && reached;
      out_data.range_error <= bad;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= CNT_W'(1);
      sp           <= '0;
      clr          <= '0;
      visited      <= '0;
      cyc          <= 1'b0;
      bad          <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_write) begin
        vertex_count <= cfg_data;
      end
      if (cmd.load_edge && !edge_ok) begin
        bad <= 1'b1;
      end
      if (cmd.start_walk) begin
        cyc     <= 1'b0;
        visited <= (n_act != '0) ? vset_t'(1) : '0;
        sp      <= (n_act != '0) ? CNT_W'(1) : '0;
      end
      if (cmd.pop) begin
        sp <= sp_dec;
      end
      if (cmd.push) begin
        sp <= sp + CNT_W'(1);
      end
      if (cmd.scan) begin
        visited <= visited | fresh;
        if ((row_m & visited & ~par_bit) != '0) begin
          cyc <= 1'b1;
        end
      end
      if (cmd.clear) begin
        clr <= clr + VTX_W'(1);
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
        bad       <= 1'b0;
        visited   <= '0;
        cyc       <= 1'b0;
        clr       <= '0;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `UTC_ASSERT_SAME(a_sp_bound, 1'b1, sp <= CNT_W'(MAX_VERTICES), "walk stack overflow")
  `UTC_ASSERT_SAME(a_pop_nonempty, cmd.pop, sp != '0, "pop from an empty walk stack")
  `UTC_ASSERT_SAME(a_push_pending, cmd.push, pending != '0, "push with no pending neighbor")
  `UTC_ASSERT_NEXT(a_finish_out, cmd.finish, out_valid, "result not presented after finish")

endmodule

/* hdl/undirected_tree_check.sv */
// -----------------------------------------------------------------------------
// Undirected tree check
// An edge transaction sets two bits of a 64 by 64 adjacency store; when an
// end is out of range only the error flag is set. An evaluate transaction
// walks the graph from vertex 0 with a stack in memory: for each vertex it
// pops the vertex, reads and scans its adjacency row, pushes each newly found
// neighbor, and then closes the vertex. The result is held in an output
// register while a clearing pass, one row per cycle, wipes the store; the
// same pass runs after reset, and no transaction is accepted until it ends.
// Configuration writes are taken at any time.
// -----------------------------------------------------------------------------
module undirected_tree_check
  import utc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  utc_in_t          in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output utc_out_t         out_data,
  input  logic             cfg_write,
  input  logic [CNT_W-1:0] cfg_data
);

  utc_cmd_t    cmd;
  utc_status_t status;

  utc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_mode  (in_data.mode),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  utc_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* sim/undirected_tree_check_checker.sv */
// -----------------------------------------------------------------------------
// Undirected tree check result checker
// Watches the input, output and configuration ports of the block, keeps its
// own copy of the adjacency store and vertex count, predicts the verdict of
// every evaluate transaction and compares each result against it field by
// field.
// -----------------------------------------------------------------------------
module undirected_tree_check_checker
  import utc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_ready,
  input  utc_in_t          in_data,
  input  logic             out_valid,
  input  logic             out_ready,
  input  utc_out_t         out_data,
  input  logic             cfg_write,
  input  logic [CNT_W-1:0] cfg_data,
  output int               error_count,
  output int               pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  vset_t            adj_rows [MAX_VERTICES];
  logic             range_flag;
  logic [CNT_W-1:0] vertex_setting;
  utc_out_t         verdict_q [$];
  int               errors = 0;

  function automatic void clear_graph();
    for (int i = 0; i < MAX_VERTICES; i++) begin
      adj_rows[i] = '0;
    end
    range_flag = 1'b0;
  endfunction

  function automatic utc_out_t tree_verdict(input int n);
    vset_t            seen;
    logic [VTX_W-1:0] parent [MAX_VERTICES];
    logic [VTX_W-1:0] stack [MAX_VERTICES];
    int               depth;
    int               v;
    logic             cyc;
    logic             reached;
    utc_out_t         r;
    seen    = '0;
    depth   = 0;
    cyc     = 1'b0;
    reached = 1'b1;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      parent[i] = '0;
    end
    if (n > 0) begin
      seen[0]  = 1'b1;
      stack[0] = '0;
      depth    = 1;
    end
    while (depth > 0) begin
      depth--;
      v = int'(stack[depth]);
      for (int w = 0; w < n; w++) begin
        if (adj_rows[v][w]) begin
          if (!seen[w]) begin
            seen[w]   = 1'b1;
            parent[w] = VTX_W'(v);
            if (depth < MAX_VERTICES) begin
              stack[depth] = VTX_W'(w);
              depth++;
            end
          end else if (VTX_W'(w) != parent[v]) begin
            cyc = 1'b1;
          end
        end
      end
    end
    for (int w = 0; w < n; w++) begin
      if (!seen[w]) begin
        reached = 1'b0;
      end
    end
    r.is_tree     = !cyc && reached;
    r.has_cycle   = cyc;
    r.all_reached = reached;
    r.range_error = range_flag;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic want, input logic got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %b, actual %b", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : watch
    int       n;
    utc_out_t want;
    if (rst) begin
      clear_graph();
      vertex_setting = CNT_W'(1);
      verdict_q.delete();
    end else begin
      n = (vertex_setting > MAX_VERTICES) ? MAX_VERTICES : int'(vertex_setting);
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %b", $time, out_data);
          errors++;
        end else begin
          want = verdict_q.pop_front();
          check_field("is_tree", want.is_tree, out_data.is_tree);
          check_field("has_cycle", want.has_cycle, out_data.has_cycle);
          check_field("all_reached", want.all_reached, out_data.all_reached);
          check_field("range_error", want.range_error, out_data.range_error);
        end
      end
      if (in_valid && in_ready) begin
        if (in_data.mode == MODE_ADD) begin
          if (in_data.end_a >= n || in_data.end_b >= n) begin
            range_flag = 1'b1;
          end else begin
            adj_rows[in_data.end_a][in_data.end_b] = 1'b1;
            adj_rows[in_data.end_b][in_data.end_a] = 1'b1;
          end
        end else begin
          verdict_q.push_back(tree_verdict(n));
          clear_graph();
        end
      end
      if (cfg_write) begin
        vertex_setting = cfg_data;
      end
    end
    error_count   <= errors;
    pending_count <= verdict_q.size();
  end

endmodule

/* sim/testbench.sv */
// -----------------------------------------------------------------------------
// Undirected tree check testbench
// Drives edge and evaluate transactions into the block, first a short directed
// set of corner cases and then random graphs (trees, forests, graphs with extra
// or parallel edges, self-loops and out-of-range edges) under several vertex
// counts and idling patterns. A separate checker predicts and compares results.
// -----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import utc_pkg::*;

  localparam int RUN_ITEMS     = 1300;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 400;

  logic             clk = 1'b0;
  logic             rst;
  logic             in_valid;
  logic             in_ready;
  utc_in_t          in_data;
  logic             out_valid;
  logic             out_ready;
  utc_out_t         out_data;
  logic             cfg_write;
  logic [CNT_W-1:0] cfg_data;
  int               fail_count;
  int               pending;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int items_sent    = 0;
  int cycle_count   = 0;

  undirected_tree_check dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data)
  );

  undirected_tree_check_checker verdict_check (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .error_count   (fail_count),
    .pending_count (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic utc_in_t edge_item(input int a, input int b);
    utc_in_t r;
    r.mode = MODE_ADD;
    if ($urandom_range(1)) begin
      r.end_a = VTX_W'(a);
      r.end_b = VTX_W'(b);
    end else begin
      r.end_a = VTX_W'(b);
      r.end_b = VTX_W'(a);
    end
    return r;
  endfunction

  function automatic utc_in_t eval_item();
    utc_in_t r;
    r.mode  = MODE_EVAL;
    r.end_a = VTX_W'($urandom);
    r.end_b = VTX_W'($urandom);
    return r;
  endfunction

  task automatic send_item(input utc_in_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_vertex_count(input int c);
    wait_drained();
    cfg_write <= 1'b1;
    cfg_data  <= CNT_W'(c);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic run_graph(input int n);
    utc_in_t edges [$];
    utc_in_t e;
    int      lbl [MAX_VERTICES];
    int      kind;
    int      drop;
    int      j;
    int      tmp;
    int      k;
    kind = $urandom_range(9);
    for (int i = 0; i < MAX_VERTICES; i++) begin
      lbl[i] = i;
    end
    for (int i = n - 1; i > 0; i--) begin
      j      = $urandom_range(i);
      tmp    = lbl[i];
      lbl[i] = lbl[j];
      lbl[j] = tmp;
    end
    drop = (kind == 7 && n > 1) ? $urandom_range(n - 1, 1) : 0;
    if (kind != 8) begin
      for (int i = 1; i < n; i++) begin
        if (i != drop) begin
          j = $urandom_range(i - 1);
          edges.insert($urandom_range(edges.size()), edge_item(lbl[i], lbl[j]));
        end
      end
    end
    case (kind)
      5: begin
        if (edges.size() > 0) begin
          e = edges[$urandom_range(edges.size() - 1)];
          edges.insert($urandom_range(edges.size()), edge_item(e.end_b, e.end_a));
        end
      end
      6: begin
        if (n > 0) begin
          edges.insert($urandom_range(edges.size()),
                       edge_item($urandom_range(n - 1), $urandom_range(n - 1)));
        end
      end
      8: begin
        k = $urandom_range(n + 2);
        repeat (k) begin
          edges.insert($urandom_range(edges.size()),
                       edge_item(($urandom_range(1) && n > 0) ? $urandom_range(n - 1)
                                                              : $urandom_range(63),
                                 ($urandom_range(1) && n > 0) ? $urandom_range(n - 1)
                                                              : $urandom_range(63)));
        end
      end
      9: begin
        if (n < MAX_VERTICES) begin
          edges.insert($urandom_range(edges.size()),
                       edge_item($urandom_range(63), $urandom_range(63, n)));
        end
      end
      default: ;
    endcase
    foreach (edges[i]) begin
      send_item(edges[i]);
    end
    send_item(eval_item());
  endtask

  initial begin
    int phase;
    int c;
    int n;
    int graphs;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_write <= 1'b0;
    cfg_data  <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // The vertex count out of reset is one.
    send_item(eval_item());

    // A self-loop on vertex 0 is ignored.
    set_vertex_count(1);
    send_item(edge_item(0, 0));
    send_item(eval_item());

    // With no vertices every edge is out of range and the walk is empty.
    set_vertex_count(0);
    send_item(edge_item(0, 0));
    send_item(eval_item());

    // A parallel edge counts once.
    set_vertex_count(3);
    send_item(edge_item(0, 1));
    send_item(edge_item(1, 2));
    send_item(edge_item(1, 0));
    send_item(eval_item());

    set_vertex_count(3);
    send_item(edge_item(0, 1));
    send_item(edge_item(2, 3));
    send_item(eval_item());

    // Lowering the count after loading hides the upper neighbors from the walk.
    set_vertex_count(4);
    send_item(edge_item(0, 1));
    send_item(edge_item(1, 2));
    send_item(edge_item(2, 3));
    set_vertex_count(3);
    send_item(eval_item());

    set_vertex_count(MAX_VERTICES);
    send_item(edge_item(63, 62));
    send_item(edge_item(0, 63));
    send_item(edge_item(31, 32));
    send_item(eval_item());

    // A count above the maximum is clipped; a self-loop elsewhere is a cycle.
    set_vertex_count(127);
    send_item(edge_item(0, 63));
    send_item(edge_item(5, 5));
    send_item(edge_item(63, 5));
    send_item(eval_item());

    phase = 0;
    while (items_sent < RUN_ITEMS) begin
      case (phase % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 72;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 72;
        end
        default: begin
          send_idle_pct = 25;
          stall_pct     = 25;
        end
      endcase
      case ($urandom_range(19))
        0:       c = 0;
        1:       c = MAX_VERTICES;
        2:       c = $urandom_range(127, MAX_VERTICES + 1);
        3:       c = $urandom_range(MAX_VERTICES - 1, 13);
        default: c = $urandom_range(12, 1);
      endcase
      set_vertex_count(c);
      n      = (c > MAX_VERTICES) ? MAX_VERTICES : c;
      graphs = (n > 16) ? $urandom_range(2, 1) : $urandom_range(6, 2);
      repeat (graphs) run_graph(n);
      phase++;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* undirected_tree_check.f */
+incdir+hdl
hdl/utc_pkg.sv
hdl/utc_ctrl.sv
hdl/utc_dpath.sv
hdl/undirected_tree_check.sv
sim/undirected_tree_check_checker.sv
sim/testbench.sv
